// File: hw/rtl/brs_pkg.sv
// brs_pkg: shared constants for the box record sorter
// no dependencies
`timescale 1ns / 1ps
package brs_pkg;
  localparam int unsigned MaxBoxesDef  = 64;
  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned RecBits      = 168;
endpackage

// File: hw/rtl/box_record_sort_yzx.sv
// box_record_sort_yzx: stable insertion sort of box records by (y, z, x)
// depends on brs_pkg and brs_mem
//
// channel  ports   direction  handshake
// input    in_*    in         start & !busy
// result   out_*   out        out_valid, one cycle, no stall
//
// records load one per cycle; the item with last_in starts an insertion sort
// in the record memory: each record is held, larger predecessors shift up one
// place, and the record is put where the scan stops; then the results are emitted.
// busy is high for the whole sort and emission.
// reset is synchronous, clears the count and the sequencer; memory contents
// are not cleared. the receiver cannot stall results.
`timescale 1ns / 1ps
module box_record_sort_yzx #(
  parameter int unsigned MAX_BOXES  = brs_pkg::MaxBoxesDef,
  parameter int unsigned COORD_BITS = brs_pkg::CoordBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [15:0] in_pos_z,
  input  logic [15:0] in_size_w,
  input  logic [15:0] in_size_h,
  input  logic [15:0] in_size_d,
  input  logic [23:0] in_orient_packed,
  input  logic [23:0] in_color_rgb,
  input  logic [7:0]  in_bin_number,
  input  logic [15:0] in_item_number,
  input  logic        in_last_in,
  output logic        out_valid,
  output logic [15:0] out_pos_x,
  output logic [15:0] out_pos_y,
  output logic [15:0] out_pos_z,
  output logic [15:0] out_size_w,
  output logic [15:0] out_size_h,
  output logic [15:0] out_size_d,
  output logic [23:0] out_orient,
  output logic [23:0] out_color,
  output logic [7:0]  out_bin,
  output logic [15:0] out_item,
  output logic        out_last_out
);
  import brs_pkg::*;
  localparam int unsigned AW = $clog2(MAX_BOXES);
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);

  typedef enum logic [2:0] {
    ST_LOAD, ST_RD_I, ST_HOLD, ST_RD_J, ST_CMP, ST_PUT, ST_EMIT_RD, ST_EMIT
  } state_t;

  state_t           state_r;
  logic [CW-1:0]    count_r, i_r, j_r, k_r;
  logic [RecBits-1:0] hold_r;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [RecBits-1:0] wdata, rdata_r, in_rec;
  logic [15:0]      mx, my, mz;
  logic             accept;

  assign mx = in_pos_x & 16'((17'd1 << COORD_BITS) - 17'd1);
  assign my = in_pos_y & 16'((17'd1 << COORD_BITS) - 17'd1);
  assign mz = in_pos_z & 16'((17'd1 << COORD_BITS) - 17'd1);
  // record layout: key y,z,x | size h,d,w | orient, color | bin, item
  assign in_rec = {my, mz, mx, in_size_h, in_size_d, in_size_w,
                   in_orient_packed, in_color_rgb, in_bin_number, in_item_number};
  assign accept = start && !busy;
  assign busy   = (state_r != ST_LOAD);

  always_comb begin
    we = 1'b0; waddr = count_r[AW-1:0]; wdata = in_rec; raddr = i_r[AW-1:0];
    case (state_r)
      ST_LOAD:    begin we = accept && (count_r < CW'(MAX_BOXES)); end
      ST_RD_I:    raddr = i_r[AW-1:0];
      ST_RD_J:    raddr = AW'(j_r - CW'(1));
      ST_CMP:     begin
        // predecessor larger: shift it up one place
        we = rdata_r[167:120] > hold_r[167:120];
        waddr = j_r[AW-1:0]; wdata = rdata_r;
      end
      ST_PUT:     begin we = 1'b1; waddr = j_r[AW-1:0]; wdata = hold_r; end
      ST_EMIT_RD: raddr = k_r[AW-1:0];
      default:    ;
    endcase
  end

  brs_mem #(.MAX_BOXES(MAX_BOXES)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata_r(rdata_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; count_r <= '0; i_r <= '0; j_r <= '0; k_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        ST_LOAD: if (accept) begin
          if (count_r < CW'(MAX_BOXES)) count_r <= count_r + CW'(1);
          if (in_last_in) begin
            i_r <= CW'(1); state_r <= ST_RD_I;
          end
        end
        ST_RD_I: begin
          if (i_r >= count_r) begin
            k_r <= '0;
            state_r <= (count_r == '0) ? ST_LOAD : ST_EMIT_RD;
          end else state_r <= ST_HOLD;
        end
        ST_HOLD: begin hold_r <= rdata_r; j_r <= i_r; state_r <= ST_RD_J; end
        ST_RD_J: state_r <= (j_r == '0) ? ST_PUT : ST_CMP;
        ST_CMP: begin
          if (rdata_r[167:120] > hold_r[167:120]) begin
            j_r <= j_r - CW'(1); state_r <= ST_RD_J;
          end else state_r <= ST_PUT;
        end
        ST_PUT: begin i_r <= i_r + CW'(1); state_r <= ST_RD_I; end
        ST_EMIT_RD: state_r <= ST_EMIT;
        ST_EMIT: begin
          out_valid    <= 1'b1;
          {out_pos_y, out_pos_z, out_pos_x, out_size_h, out_size_d, out_size_w,
           out_orient, out_color, out_bin, out_item} <= rdata_r;
          out_last_out <= (k_r + CW'(1) == count_r);
          if (k_r + CW'(1) == count_r) begin
            count_r <= '0; state_r <= ST_LOAD;
          end else begin
            k_r <= k_r + CW'(1); state_r <= ST_EMIT_RD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end
endmodule

// File: hw/rtl/brs_mem.sv
// brs_mem: record memory, one write port and one registered read port
// depends on brs_pkg
`timescale 1ns / 1ps
module brs_mem #(
  parameter int unsigned MAX_BOXES = brs_pkg::MaxBoxesDef
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [$clog2(MAX_BOXES)-1:0]          waddr,
  input  logic [brs_pkg::RecBits-1:0]           wdata,
  input  logic [$clog2(MAX_BOXES)-1:0]          raddr,
  output logic [brs_pkg::RecBits-1:0]           rdata_r
);
  import brs_pkg::*;
  logic [RecBits-1:0] mem [MAX_BOXES];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end
endmodule
